// ===== sv/tolerance_window_pair_matcher_macros.svh =====
// Assertion macros for the tolerance window pair matcher.
// Used by the top level; no other dependencies.
`ifndef TOLERANCE_WINDOW_PAIR_MATCHER_MACROS_SVH
`define TOLERANCE_WINDOW_PAIR_MATCHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TWPM_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("twpm assertion failed");
`define TWPM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("twpm assertion failed");
`else
`define TWPM_ASSERT_IMPL(label, clk, rst_n, a, b)
`define TWPM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/twpm_pkg.sv =====
// Shared constants and types for the tolerance window pair matcher.
// No dependencies.
package twpm_pkg;
	localparam int MAX_FEATURES = 4096;
	localparam int IDX_W = $clog2(MAX_FEATURES);
	localparam int CNT_W = IDX_W + 1;
	localparam int TIME_W = 20;
	localparam int MASS_W = 26;
	localparam int CHG_W = 4;
	localparam int HITS_W = 13;
	localparam int BEST_W = 12;
	localparam int CLASS_W = 2;
	localparam int OP_W = 2;
	localparam int FRAC_W = 17;
	localparam int REM_W = MASS_W + 1;
	localparam int SCORE_W = 2 * FRAC_W;
	localparam int ENTRY_W = TIME_W + MASS_W;
	localparam int ADDR_W = 3;

	localparam logic [TIME_W-1:0] TIME_TOL_RESET = TIME_W'(2000);
	localparam logic [MASS_W-1:0] MASS_TOL_RESET = MASS_W'(2500);

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic REG_TIME_TOL = 1'b0;
	localparam logic REG_MASS_TOL = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage

// ===== sv/twpm_channels.sv =====
// Request and result channel interfaces of the pair matcher.
// Depends on twpm_pkg.
interface twpm_feed_if;
	logic valid;
	logic ready;
	logic [twpm_pkg::OP_W-1:0] operation;
	logic [twpm_pkg::TIME_W-1:0] first_time;
	logic [twpm_pkg::MASS_W-1:0] first_mass;
	logic [twpm_pkg::TIME_W-1:0] second_time;
	logic [twpm_pkg::MASS_W-1:0] second_mass;
	logic [twpm_pkg::CHG_W-1:0] charge;
	modport source (output valid, operation, first_time, first_mass, second_time,
		second_mass, charge, input ready);
	modport sink (input valid, operation, first_time, first_mass, second_time,
		second_mass, charge, output ready);
endinterface

interface twpm_result_if;
	logic valid;
	logic ready;
	logic [twpm_pkg::CLASS_W-1:0] pair_class;
	logic [twpm_pkg::HITS_W-1:0] first_hits;
	logic [twpm_pkg::HITS_W-1:0] second_hits;
	logic [twpm_pkg::BEST_W-1:0] first_best;
	logic [twpm_pkg::BEST_W-1:0] second_best;
	modport source (output valid, pair_class, first_hits, second_hits, first_best,
		second_best, input ready);
	modport sink (input valid, pair_class, first_hits, second_hits, first_best,
		second_best, output ready);
endinterface

// ===== sv/twpm_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module twpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/twpm_div.sv =====
// Restoring divider: floor(x * 2^16 / d) for x <= d, one quotient bit a cycle.
// Depends on twpm_pkg.
module twpm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [twpm_pkg::MASS_W-1:0]   dividend,
	input  logic [twpm_pkg::MASS_W-1:0]   divisor,
	output logic [twpm_pkg::FRAC_W-1:0]   quotient,
	output twpm_pkg::div_stat_t           stat
);
	localparam int STEP_W = $clog2(twpm_pkg::FRAC_W + 1);

	logic [twpm_pkg::REM_W-1:0]  rem_q;
	logic [twpm_pkg::MASS_W-1:0] div_q;
	logic [twpm_pkg::FRAC_W-1:0] quo_q;
	logic [STEP_W-1:0]           step_q;
	logic                        first_q;
	logic                        busy_q;
	logic                        done_q;
	logic [twpm_pkg::REM_W-1:0]  trial;
	logic                        ge;

	// first step takes the integer bit without a shift
	assign trial = first_q ? rem_q : {rem_q[twpm_pkg::REM_W-2:0], 1'b0};
	assign ge = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			first_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				first_q <= 1'b1;
				step_q <= STEP_W'(twpm_pkg::FRAC_W);
			end else if (busy_q) begin
				first_q <= 1'b0;
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, div_q} : trial;
			quo_q <= {quo_q[twpm_pkg::FRAC_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

// ===== sv/tolerance_window_pair_matcher.sv =====
// Top level of the tolerance window pair matcher: sequencer, table and registers.
// Depends on twpm_pkg, the channel interfaces, twpm_ram, twpm_div and the macros.
//
// Usage: requests enter on feed (valid/ready). A clear empties the table, a load
// writes the next free table entry (ignored when the table is full). A query
// scans the stored table once for each pair element: per entry a RAM read and a
// window check, and per hit the two divisions of the shared divider, the product
// and the compare. The divider dominates the time per hit, the single RAM read
// port the time per entry.
// feed.ready is high only while the sequencer is idle.
// One result per query appears on result from an output register; a new
// request is taken while it waits, and a finished query holds in its last
// state until the output register is free, so a stalled receiver loses nothing.
// Reset empties the table (count to zero) and restores the tolerance
// registers; the table memory itself is not cleared.
// The APB port writes time_tolerance at 0 and mass_tolerance at 4.
`include "tolerance_window_pair_matcher_macros.svh"
module tolerance_window_pair_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	twpm_feed_if.sink                     feed,
	twpm_result_if.source                 result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [twpm_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_CHK  = 8'b0000_0100,
		S_DIVM = 8'b0000_1000,
		S_DIVT = 8'b0001_0000,
		S_MUL  = 8'b0010_0000,
		S_CMP  = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	logic [twpm_pkg::TIME_W-1:0]  ttol_q;
	logic [twpm_pkg::MASS_W-1:0]  mtol_q;
	logic [twpm_pkg::CNT_W-1:0]   cnt_q;
	logic [twpm_pkg::IDX_W-1:0]   idx_q;
	logic                         elem_q;
	logic [twpm_pkg::TIME_W-1:0]  t1_q, t2_q;
	logic [twpm_pkg::MASS_W-1:0]  m1_q, m2_q;
	logic [twpm_pkg::CHG_W-1:0]   chg_q;
	logic [twpm_pkg::CNT_W-1:0]   hits_q, fhits_q;
	logic [twpm_pkg::IDX_W-1:0]   best_q, fbest_q;
	logic                         have_q;
	logic [twpm_pkg::SCORE_W-1:0] bscore_q, score_q;
	logic [twpm_pkg::FRAC_W-1:0]  fm_q, ft_q;
	logic [twpm_pkg::TIME_W-1:0]  drt_q;
	logic                         out_valid_q;
	logic [twpm_pkg::CLASS_W-1:0] o_class_q;
	logic [twpm_pkg::HITS_W-1:0]  o_fh_q, o_sh_q;
	logic [twpm_pkg::BEST_W-1:0]  o_fb_q, o_sb_q;

	logic                         accept, wr_cfg;
	logic [twpm_pkg::ENTRY_W-1:0] rdata;
	logic [twpm_pkg::TIME_W-1:0]  e_time, cur_t, drt;
	logic [twpm_pkg::MASS_W-1:0]  e_mass, cur_m, dmz_raw;
	logic [twpm_pkg::MASS_W+twpm_pkg::CHG_W-1:0] dmz;
	logic                         hit, last, fin_load;
	logic                         div_go;
	logic [twpm_pkg::MASS_W-1:0]  div_x, div_d;
	logic [twpm_pkg::FRAC_W-1:0]  quot;
	twpm_pkg::div_stat_t          dstat;

	// configuration port
	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite;
	assign prdata = (paddr[2] == twpm_pkg::REG_MASS_TOL)
		? {6'd0, mtol_q} : {12'd0, ttol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttol_q <= twpm_pkg::TIME_TOL_RESET;
			mtol_q <= twpm_pkg::MASS_TOL_RESET;
		end else if (wr_cfg) begin
			if (paddr[2] == twpm_pkg::REG_MASS_TOL) begin
				mtol_q <= pwdata[twpm_pkg::MASS_W-1:0];
			end else begin
				ttol_q <= pwdata[twpm_pkg::TIME_W-1:0];
			end
		end
	end

	assign feed.ready = (state_q == S_IDLE);
	assign accept = feed.valid && feed.ready;

	twpm_ram #(.WIDTH(twpm_pkg::ENTRY_W), .DEPTH(twpm_pkg::MAX_FEATURES)) u_table (
		.clk   (clk),
		.we    (accept && feed.operation == twpm_pkg::OP_LOAD
			&& cnt_q < twpm_pkg::CNT_W'(twpm_pkg::MAX_FEATURES)),
		.waddr (cnt_q[twpm_pkg::IDX_W-1:0]),
		.wdata ({feed.first_time, feed.first_mass}),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// window check on the entry just read
	assign e_time = rdata[twpm_pkg::ENTRY_W-1:twpm_pkg::MASS_W];
	assign e_mass = rdata[twpm_pkg::MASS_W-1:0];
	assign cur_t = elem_q ? t2_q : t1_q;
	assign cur_m = elem_q ? m2_q : m1_q;
	assign drt = (e_time > cur_t) ? e_time - cur_t : cur_t - e_time;
	assign dmz_raw = (e_mass > cur_m) ? e_mass - cur_m : cur_m - e_mass;
	assign dmz = {{twpm_pkg::CHG_W{1'b0}}, dmz_raw}
		* {{twpm_pkg::MASS_W{1'b0}}, chg_q};
	assign hit = (drt < ttol_q) && (dmz < {{twpm_pkg::CHG_W{1'b0}}, mtol_q});
	assign last = ({1'b0, idx_q} + twpm_pkg::CNT_W'(1)) == cnt_q;
	assign fin_load = (state_q == S_FIN) && (!out_valid_q || result.ready);

	twpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_x),
		.divisor  (div_d),
		.quotient (quot),
		.stat     (dstat)
	);

	always_comb begin
		div_go = 1'b0;
		div_x = mtol_q - dmz[twpm_pkg::MASS_W-1:0];
		div_d = mtol_q;
		if (state_q == S_CHK && hit) begin
			div_go = 1'b1;
		end else if (state_q == S_DIVM && dstat.done) begin
			div_go = 1'b1;
			div_x = {6'd0, ttol_q - drt_q};
			div_d = {6'd0, ttol_q};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && feed.operation == twpm_pkg::OP_QUERY) begin
					state_d = (cnt_q == '0) ? S_FIN : S_RD;
				end
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (hit) begin
					state_d = S_DIVM;
				end else if (last && elem_q) begin
					state_d = S_FIN;
				end else begin
					state_d = S_RD;
				end
			end
			S_DIVM: if (dstat.done) state_d = S_DIVT;
			S_DIVT: if (dstat.done) state_d = S_MUL;
			S_MUL: state_d = S_CMP;
			S_CMP: state_d = (last && elem_q) ? S_FIN : S_RD;
			S_FIN: if (fin_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// step to the next entry, or to the second element, after an entry is done
	logic adv;
	assign adv = (state_q == S_CHK && !hit) || state_q == S_CMP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			elem_q <= 1'b0;
			hits_q <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			fhits_q <= '0;
			fbest_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (feed.operation)
					twpm_pkg::OP_CLEAR: cnt_q <= '0;
					twpm_pkg::OP_LOAD: begin
						if (cnt_q < twpm_pkg::CNT_W'(twpm_pkg::MAX_FEATURES)) begin
							cnt_q <= cnt_q + twpm_pkg::CNT_W'(1);
						end
					end
					twpm_pkg::OP_QUERY: begin
						idx_q <= '0;
						elem_q <= 1'b0;
						hits_q <= '0;
						have_q <= 1'b0;
						best_q <= '0;
						fhits_q <= '0;
						fbest_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == S_CHK && hit) begin
				hits_q <= hits_q + twpm_pkg::CNT_W'(1);
			end
			if (state_q == S_CMP && (!have_q || score_q > bscore_q)) begin
				have_q <= 1'b1;
				best_q <= idx_q;
			end
			if (adv) begin
				if (!last) begin
					idx_q <= idx_q + twpm_pkg::IDX_W'(1);
				end else if (!elem_q) begin
					// first element done: keep its result, rescan for the second
					fhits_q <= (state_q == S_CHK) ? hits_q : hits_q;
					fbest_q <= (state_q == S_CMP && (!have_q || score_q > bscore_q))
						? idx_q : best_q;
					elem_q <= 1'b1;
					idx_q <= '0;
					hits_q <= '0;
					have_q <= 1'b0;
					best_q <= '0;
				end
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t1_q <= feed.first_time;
			m1_q <= feed.first_mass;
			t2_q <= feed.second_time;
			m2_q <= feed.second_mass;
			chg_q <= (feed.charge == '0) ? twpm_pkg::CHG_W'(1) : feed.charge;
		end
		if (state_q == S_CHK) begin
			drt_q <= drt;
		end
		if (state_q == S_DIVM && dstat.done) begin
			fm_q <= quot;
		end
		if (state_q == S_DIVT && dstat.done) begin
			ft_q <= quot;
		end
		if (state_q == S_MUL) begin
			score_q <= {{twpm_pkg::FRAC_W{1'b0}}, fm_q} * {{twpm_pkg::FRAC_W{1'b0}}, ft_q};
		end
		if (state_q == S_CMP && (!have_q || score_q > bscore_q)) begin
			bscore_q <= score_q;
		end
		if (fin_load) begin
			o_class_q <= twpm_pkg::CLASS_W'({1'b0, fhits_q != '0})
				+ twpm_pkg::CLASS_W'({1'b0, hits_q != '0});
			o_fh_q <= twpm_pkg::HITS_W'(fhits_q);
			o_sh_q <= twpm_pkg::HITS_W'(hits_q);
			o_fb_q <= twpm_pkg::BEST_W'(fbest_q);
			o_sb_q <= twpm_pkg::BEST_W'(best_q);
		end
	end

	assign result.valid = out_valid_q;
	assign result.pair_class = o_class_q;
	assign result.first_hits = o_fh_q;
	assign result.second_hits = o_sh_q;
	assign result.first_best = o_fb_q;
	assign result.second_best = o_sb_q;

	`TWPM_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1,
		cnt_q <= twpm_pkg::CNT_W'(twpm_pkg::MAX_FEATURES))
	`TWPM_ASSERT_IMPL(a_div_owner, clk, arst_n, dstat.done,
		state_q == S_DIVM || state_q == S_DIVT)
	`TWPM_ASSERT_NEXT(a_query_busy, clk, arst_n,
		accept && feed.operation == twpm_pkg::OP_QUERY, !feed.ready)
endmodule

// ===== tb/tolerance_window_pair_matcher_test.sv =====
// Self-checking test of the tolerance window pair matcher: table loads, clears and
// pair queries checked against a cycle-free scoring model. Depends on twpm_pkg,
// the channel interfaces and the top level.
`timescale 1ns / 1ps
module tolerance_window_pair_matcher_test;
	typedef struct packed {
		logic [twpm_pkg::OP_W-1:0] operation;
		logic [twpm_pkg::TIME_W-1:0] first_time;
		logic [twpm_pkg::MASS_W-1:0] first_mass;
		logic [twpm_pkg::TIME_W-1:0] second_time;
		logic [twpm_pkg::MASS_W-1:0] second_mass;
		logic [twpm_pkg::CHG_W-1:0] charge;
	} request_t;

	typedef struct packed {
		logic [twpm_pkg::CLASS_W-1:0] pair_class;
		logic [twpm_pkg::HITS_W-1:0] first_hits;
		logic [twpm_pkg::HITS_W-1:0] second_hits;
		logic [twpm_pkg::BEST_W-1:0] first_best;
		logic [twpm_pkg::BEST_W-1:0] second_best;
	} match_t;

	localparam logic [twpm_pkg::ADDR_W-1:0] ADDR_TIME_TOL = 3'd0;
	localparam logic [twpm_pkg::ADDR_W-1:0] ADDR_MASS_TOL = 3'd4;
	localparam logic [twpm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [twpm_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	twpm_feed_if feed ();
	twpm_result_if result ();

	tolerance_window_pair_matcher u_top (
		.clk(clk), .arst_n(arst_n), .feed(feed.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	logic [twpm_pkg::TIME_W-1:0] table_time[twpm_pkg::MAX_FEATURES];
	logic [twpm_pkg::MASS_W-1:0] table_mass[twpm_pkg::MAX_FEATURES];
	int unsigned table_count;
	logic [63:0] time_tol, mass_tol;

	request_t pending_requests[$];
	match_t expected_matches[$];
	int unsigned failures;
	int unsigned stall_cycles;
	bit idle_feed, idle_result;
	bit hold_result;
	int unsigned sent_count;

	function automatic void scan_table(input logic [63:0] t, input logic [63:0] m,
			input logic [63:0] chg, output logic [twpm_pkg::HITS_W-1:0] hits,
			output logic [twpm_pkg::BEST_W-1:0] best);
		logic [63:0] drt, dmz, fm, ft, score, top_score;
		int unsigned n;
		bit have;
		n = 0;
		have = 0;
		top_score = 0;
		best = '0;
		for (int i = 0; i < table_count; i++) begin
			drt = table_time[i] > t ? table_time[i] - t : t - table_time[i];
			dmz = (table_mass[i] > m ? table_mass[i] - m : m - table_mass[i]) * chg;
			if (drt < time_tol && dmz < mass_tol) begin
				fm = ((mass_tol - dmz) << 16) / mass_tol;
				ft = ((time_tol - drt) << 16) / time_tol;
				score = fm * ft;
				n++;
				if (!have || score > top_score) begin
					have = 1;
					top_score = score;
					best = twpm_pkg::BEST_W'(i);
				end
			end
		end
		hits = twpm_pkg::HITS_W'(n);
	endfunction

	function automatic void queue_req(input request_t r);
		pending_requests = {pending_requests, r};
	endfunction

	function automatic void apply_request(input request_t r);
		match_t e;
		logic [63:0] chg;
		if (r.operation == twpm_pkg::OP_CLEAR) begin
			table_count = 0;
		end else if (r.operation == twpm_pkg::OP_LOAD) begin
			if (table_count < twpm_pkg::MAX_FEATURES) begin
				table_time[table_count] = r.first_time;
				table_mass[table_count] = r.first_mass;
				table_count++;
			end
		end else if (r.operation == twpm_pkg::OP_QUERY) begin
			chg = (r.charge == 0) ? 64'd1 : 64'(r.charge);
			scan_table(r.first_time, r.first_mass, chg, e.first_hits, e.first_best);
			scan_table(r.second_time, r.second_mass, chg, e.second_hits, e.second_best);
			e.pair_class = twpm_pkg::CLASS_W'(e.first_hits != 0)
				+ twpm_pkg::CLASS_W'(e.second_hits != 0);
			expected_matches = {expected_matches, e};
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed.valid <= 1'b0;
			{feed.operation, feed.first_time, feed.first_mass, feed.second_time,
				feed.second_mass, feed.charge} <= '0;
		end else begin
			if (feed.valid && feed.ready) begin
				apply_request(request_t'({feed.operation, feed.first_time, feed.first_mass,
					feed.second_time, feed.second_mass, feed.charge}));
				void'(pending_requests.pop_front());
				sent_count++;
			end
			if ((!feed.valid || feed.ready) && pending_requests.size() > 0 && !idle_feed) begin
				{feed.operation, feed.first_time, feed.first_mass, feed.second_time,
					feed.second_mass, feed.charge} <= pending_requests[0];
				feed.valid <= 1'b1;
			end else if (feed.valid && feed.ready) begin
				feed.valid <= 1'b0;
			end
			if ((feed.valid && feed.ready) || (result.valid && result.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		match_t got, want;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				got = {result.pair_class, result.first_hits, result.second_hits,
					result.first_best, result.second_best};
				if (expected_matches.size() == 0) begin
					$error("result with no query outstanding");
					failures++;
				end else begin
					want = expected_matches.pop_front();
					if (got.pair_class !== want.pair_class) begin
						$error("pair_class exp %0d got %0d", want.pair_class, got.pair_class);
						failures++;
					end
					if (got.first_hits !== want.first_hits) begin
						$error("first_hits exp %0d got %0d", want.first_hits, got.first_hits);
						failures++;
					end
					if (got.second_hits !== want.second_hits) begin
						$error("second_hits exp %0d got %0d", want.second_hits, got.second_hits);
						failures++;
					end
					if (got.first_best !== want.first_best) begin
						$error("first_best exp %0d got %0d", want.first_best, got.first_best);
						failures++;
					end
					if (got.second_best !== want.second_best) begin
						$error("second_best exp %0d got %0d", want.second_best, got.second_best);
						failures++;
					end
				end
			end
			result.ready <= !idle_result && !hold_result;
		end
	end

	bit calm;
	always @(posedge clk) begin
		idle_feed <= calm ? 1'b0 : ($urandom_range(99) < 38);
		idle_result <= calm ? 1'b0 : ($urandom_range(99) < 38);
	end

	always @(posedge clk) begin
		if (stall_cycles > STALL_LIMIT) begin
			$display("[tolerance_window_pair_matcher] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [twpm_pkg::ADDR_W-1:0] addr,
			input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_TIME_TOL)
			time_tol = data & 32'hFFFFF;
		else
			mass_tol = data & 32'h3FFFFFF;
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || feed.valid || expected_matches.size() > 0)
			@(posedge clk);
		// idle padding; a trailing clear or load already took effect when it was accepted
		repeat (20) @(posedge clk);
	endtask

	function automatic request_t make_req(input logic [twpm_pkg::OP_W-1:0] op,
			input logic [twpm_pkg::TIME_W-1:0] t1, input logic [twpm_pkg::MASS_W-1:0] m1,
			input logic [twpm_pkg::TIME_W-1:0] t2, input logic [twpm_pkg::MASS_W-1:0] m2,
			input logic [twpm_pkg::CHG_W-1:0] chg);
		request_t r;
		r.operation = op;
		r.first_time = t1;
		r.first_mass = m1;
		r.second_time = t2;
		r.second_mass = m2;
		r.charge = chg;
		return r;
	endfunction

	function automatic request_t near_req(input logic [twpm_pkg::OP_W-1:0] op,
			input logic [twpm_pkg::TIME_W-1:0] t, input logic [twpm_pkg::MASS_W-1:0] m);
		return make_req(op,
			t + twpm_pkg::TIME_W'($urandom_range(3000)) - twpm_pkg::TIME_W'(1500),
			m + twpm_pkg::MASS_W'($urandom_range(3000)) - twpm_pkg::MASS_W'(1500),
			t + twpm_pkg::TIME_W'($urandom_range(3000)) - twpm_pkg::TIME_W'(1500),
			m + twpm_pkg::MASS_W'($urandom_range(3000)) - twpm_pkg::MASS_W'(1500),
			twpm_pkg::CHG_W'($urandom_range(15)));
	endfunction

	function automatic request_t rand_req(input logic [twpm_pkg::OP_W-1:0] op);
		return make_req(op, twpm_pkg::TIME_W'($urandom), twpm_pkg::MASS_W'($urandom),
			twpm_pkg::TIME_W'($urandom), twpm_pkg::MASS_W'($urandom),
			twpm_pkg::CHG_W'($urandom));
	endfunction

	// mix loads around a center with queries near it, plus clears, unused opcodes and random queries
	task automatic random_phase(input int n_items);
		logic [twpm_pkg::TIME_W-1:0] ct;
		logic [twpm_pkg::MASS_W-1:0] cm;
		int k;
		ct = twpm_pkg::TIME_W'($urandom);
		cm = twpm_pkg::MASS_W'($urandom);
		for (k = 0; k < n_items; k++) begin
			case ($urandom_range(19))
				0: queue_req(make_req(twpm_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
				1: queue_req(rand_req(OP_UNUSED));
				2: queue_req(rand_req(twpm_pkg::OP_QUERY));
				3, 4, 5, 6, 7, 8, 9, 10: queue_req(near_req(twpm_pkg::OP_LOAD, ct, cm));
				default: queue_req(near_req(twpm_pkg::OP_QUERY, ct, cm));
			endcase
		end
	endtask

	initial begin
		time_tol = twpm_pkg::TIME_TOL_RESET;
		mass_tol = twpm_pkg::MASS_TOL_RESET;
		table_count = 0;
		failures = 0;
		stall_cycles = 0;
		sent_count = 0;
		hold_result = 1'b0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, ties, empty table, unknown opcode, charge corners
		queue_req(make_req(twpm_pkg::OP_QUERY, '0, '0, '1, '1, 4'd1));
		queue_req(make_req(twpm_pkg::OP_LOAD, '0, '0, '0, '0, 4'd0));
		queue_req(make_req(twpm_pkg::OP_LOAD, '1, '1, '1, '1, '1));
		queue_req(make_req(twpm_pkg::OP_LOAD, 20'd1000, 26'd5000, '0, '0, 4'd1));
		queue_req(make_req(twpm_pkg::OP_LOAD, 20'd1000, 26'd5000, '0, '0, 4'd1));
		queue_req(make_req(twpm_pkg::OP_LOAD, 20'd2999, 26'd7499, '0, '0, 4'd1));
		queue_req(make_req(twpm_pkg::OP_QUERY, 20'd1000, 26'd5000, '1, '1, 4'd1));
		queue_req(make_req(twpm_pkg::OP_QUERY, 20'd1000, 26'd5000, 20'd1999, 26'd2501,
			4'd0));
		queue_req(make_req(twpm_pkg::OP_QUERY, 20'd3000, 26'd5000, 20'd1000, 26'd7500,
			4'd8));
		queue_req(make_req(twpm_pkg::OP_QUERY, 20'd1100, 26'd5100, '0, '0, 4'd15));
		queue_req(make_req(OP_UNUSED, '1, '1, '1, '1, '1));
		queue_req(make_req(twpm_pkg::OP_QUERY, '1, '1, '0, '0, 4'd2));
		queue_req(make_req(twpm_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
		queue_req(make_req(twpm_pkg::OP_QUERY, 20'd1000, 26'd5000, '0, '0, 4'd1));
		drain();

		write_reg(ADDR_TIME_TOL, 32'hFFFFF);
		write_reg(ADDR_MASS_TOL, 32'h3FFFFFF);
		queue_req(make_req(twpm_pkg::OP_LOAD, '1, '0, '0, '0, 4'd1));
		queue_req(make_req(twpm_pkg::OP_LOAD, '0, '1, '0, '0, 4'd1));
		queue_req(make_req(twpm_pkg::OP_QUERY, '0, '0, '1, '1, 4'd1));
		queue_req(make_req(twpm_pkg::OP_QUERY, 20'h80000, 26'h2000000, '1, '0, 4'd8));
		drain();

		write_reg(ADDR_TIME_TOL, 32'd1);
		write_reg(ADDR_MASS_TOL, 32'd1);
		random_phase(20);
		drain();

		// receiver holds off while requests keep coming
		write_reg(ADDR_TIME_TOL, 32'd2000);
		write_reg(ADDR_MASS_TOL, 32'd2500);
		hold_result = 1'b1;
		random_phase(40);
		repeat (3000) @(posedge clk);
		hold_result = 1'b0;
		drain();

		calm = 1'b1;
		write_reg(ADDR_TIME_TOL, 32'd700);
		write_reg(ADDR_MASS_TOL, 32'd9000);
		random_phase(40);
		drain();
		calm = 1'b0;

		write_reg(ADDR_TIME_TOL, 32'd1500);
		write_reg(ADDR_MASS_TOL, 32'd1200);
		random_phase(22);
		drain();

		if (failures == 0)
			$display("[tolerance_window_pair_matcher] OK");
		else
			$display("[tolerance_window_pair_matcher] ERROR");
		$finish;
	end
endmodule
